// File: design/slfa_pkg.sv
package slfa_pkg;

    localparam int ADDR_W = 17;
    localparam int SIZE_W = 16;
    localparam int IDX_W  = 9;
    localparam int CNT_W  = 9;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NOFIT   = 2'd1;
    localparam logic [1:0] STS_UNKNOWN = 2'd2;
    localparam logic [1:0] STS_FULL    = 2'd3;

    localparam logic [1:0] ARENA_SMALL  = 2'd0;
    localparam logic [1:0] ARENA_MEDIUM = 2'd1;
    localparam logic [1:0] ARENA_LARGE  = 2'd2;

    localparam logic [1:0] CFG_FIT_MODE     = 2'd0;
    localparam logic [1:0] CFG_MERGE_ENABLE = 2'd1;
    localparam logic [1:0] CFG_SMALL_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_MEDIUM_LIMIT = 2'd3;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_SPLIT,
        OP_DELETE,
        OP_MERGE_BOTH,
        OP_MERGE_PREV,
        OP_MERGE_NEXT,
        OP_INSERT
    } op_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } ent_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  pos;
        logic [SIZE_W-1:0] req;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              fit_first;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] bytes;
        logic [SIZE_W-1:0] big;
        logic              fit_found;
        logic [IDX_W-1:0]  fit_idx;
        logic [SIZE_W-1:0] fit_size;
        logic [ADDR_W-1:0] fit_addr;
        logic              pos_found;
        logic [IDX_W-1:0]  pos_idx;
        logic              mn;
        logic              mp;
    } acc_t;

endpackage

// File: design/slfa_cell.sv
module slfa_cell
    import slfa_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int HDR        = 16,
    parameter bit INIT_VALID = 1'b0,
    parameter int INIT_ADDR  = 0,
    parameter int INIT_SIZE  = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  ent_t left_ent,
    input  ent_t right_ent,
    input  acc_t acc_in,
    output ent_t ent,
    output acc_t acc
);

    localparam logic [IDX_W:0]  MY         = (IDX_W+1)'(IDX);
    localparam logic [IDX_W:0]  MY_NEXT    = (IDX_W+1)'(IDX + 1);
    localparam logic [ADDR_W:0] HW         = (ADDR_W+1)'(HDR);
    localparam bit              NOT_FIRST  = (IDX != 0);

    ent_t ent_reg, ent_next;
    acc_t acc_reg, acc_next;

    logic [IDX_W:0]  pos_w;
    logic            at_pos, at_prev, past_pos, from_pos;
    logic [ADDR_W:0] split_addr, split_size, both_size, prev_size, next_size;
    logic [ADDR_W:0] end_new, left_end;
    logic            lt_self, lt_left, is_pos, mn_here, mp_here, hit;

    always_comb
    begin
        pos_w    = {1'b0, cmd.pos};
        at_pos   = (MY == pos_w);
        at_prev  = (MY_NEXT == pos_w);
        past_pos = (MY > pos_w);
        from_pos = (MY >= pos_w);

        split_addr = {1'b0, ent_reg.addr} + HW + (ADDR_W+1)'(cmd.req);
        split_size = (ADDR_W+1)'(ent_reg.size) - (ADDR_W+1)'(cmd.req) - HW;
        both_size  = (ADDR_W+1)'(ent_reg.size) + HW + HW + (ADDR_W+1)'(cmd.size)
                   + (ADDR_W+1)'(right_ent.size);
        prev_size  = (ADDR_W+1)'(ent_reg.size) + HW + (ADDR_W+1)'(cmd.size);
        next_size  = (ADDR_W+1)'(cmd.size) + HW + (ADDR_W+1)'(ent_reg.size);

        ent_next = ent_reg;
        case (cmd.op)
            OP_SPLIT:
            begin
                if (at_pos)
                begin
                    ent_next.addr = split_addr[ADDR_W-1:0];
                    ent_next.size = split_size[SIZE_W-1:0];
                end
            end
            OP_DELETE:
            begin
                if (from_pos)
                    ent_next = right_ent;
            end
            OP_MERGE_BOTH:
            begin
                if (at_prev)
                    ent_next.size = both_size[SIZE_W-1:0];
                else if (from_pos)
                    ent_next = right_ent;
            end
            OP_MERGE_PREV:
            begin
                if (at_prev)
                    ent_next.size = prev_size[SIZE_W-1:0];
            end
            OP_MERGE_NEXT:
            begin
                if (at_pos)
                begin
                    ent_next.addr = cmd.start;
                    ent_next.size = next_size[SIZE_W-1:0];
                end
            end
            OP_INSERT:
            begin
                if (at_pos)
                begin
                    ent_next.valid = 1'b1;
                    ent_next.addr  = cmd.start;
                    ent_next.size  = cmd.size;
                end
                else if (past_pos)
                    ent_next = left_ent;
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    // running statistics, fit search and insert position ripple one cell per cycle
    always_comb
    begin
        lt_self  = ent_reg.valid && (ent_reg.addr < cmd.start);
        lt_left  = NOT_FIRST && left_ent.valid && (left_ent.addr < cmd.start);
        is_pos   = !lt_self && (!NOT_FIRST || lt_left);
        end_new  = {1'b0, cmd.start} + HW + (ADDR_W+1)'(cmd.size);
        mn_here  = ent_reg.valid && (end_new == {1'b0, ent_reg.addr});
        left_end = {1'b0, left_ent.addr} + HW + (ADDR_W+1)'(left_ent.size);
        mp_here  = NOT_FIRST && left_ent.valid && (left_end == {1'b0, cmd.start});
        hit      = ent_reg.valid && (ent_reg.size >= cmd.req);

        acc_next = acc_in;
        if (ent_reg.valid)
        begin
            acc_next.cnt   = acc_in.cnt + CNT_W'(1);
            acc_next.bytes = acc_in.bytes + ADDR_W'(ent_reg.size);
            if (ent_reg.size > acc_in.big)
                acc_next.big = ent_reg.size;
        end
        if (hit && (!acc_in.fit_found || (!cmd.fit_first && ent_reg.size < acc_in.fit_size)))
        begin
            acc_next.fit_found = 1'b1;
            acc_next.fit_idx   = MY[IDX_W-1:0];
            acc_next.fit_size  = ent_reg.size;
            acc_next.fit_addr  = ent_reg.addr;
        end
        if (!acc_in.pos_found && is_pos)
        begin
            acc_next.pos_found = 1'b1;
            acc_next.pos_idx   = MY[IDX_W-1:0];
            acc_next.mn        = mn_here;
            acc_next.mp        = mp_here;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg.valid <= INIT_VALID;
            ent_reg.addr  <= ADDR_W'(INIT_ADDR);
            ent_reg.size  <= SIZE_W'(INIT_SIZE);
            acc_reg       <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
            acc_reg <= acc_next;
        end
    end

    assign ent = ent_reg;
    assign acc = acc_reg;

endmodule

// File: design/slfa_chain.sv
module slfa_chain
    import slfa_pkg::*;
#(
    parameter int N     = 64,
    parameter int HDR   = 16,
    parameter int BASE  = 0,
    parameter int BYTES = 4096
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    output acc_t total
);

    localparam logic [ADDR_W:0] HW = (ADDR_W+1)'(HDR);

    ent_t ents [N];
    acc_t accs [N];
    logic [ADDR_W:0] last_end;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            ent_t left_w, right_w;
            acc_t in_w;
            if (k == 0)
            begin : g_head
                assign left_w = '0;
                assign in_w   = '0;
            end
            else
            begin : g_body
                assign left_w = ents[k-1];
                assign in_w   = accs[k-1];
            end
            if (k == N-1)
            begin : g_tail
                assign right_w = '0;
            end
            else
            begin : g_mid
                assign right_w = ents[k+1];
            end
            slfa_cell #(
                .IDX        (k),
                .HDR        (HDR),
                .INIT_VALID (k == 0),
                .INIT_ADDR  (BASE),
                .INIT_SIZE  (BYTES - HDR)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .left_ent  (left_w),
                .right_ent (right_w),
                .acc_in    (in_w),
                .ent       (ents[k]),
                .acc       (accs[k])
            );
        end
    endgenerate

    // a freed block above every entry lands past the last cell
    always_comb
    begin
        last_end = {1'b0, ents[N-1].addr} + HW + (ADDR_W+1)'(ents[N-1].size);
        total    = accs[N-1];
        if (!accs[N-1].pos_found)
        begin
            total.pos_found = 1'b1;
            total.pos_idx   = IDX_W'(N);
            total.mn        = 1'b0;
            total.mp        = ents[N-1].valid && (last_end == {1'b0, cmd.start});
        end
    end

endmodule

// File: design/segregated_free_list_allocator_top.sv
// Segregated-fit heap allocator over three arenas (small, medium, large).
// Input channel s_*: one transfer is one request, allocate or free, selected
// by s_tuser. Output channel m_*: exactly one result transfer per request,
// carrying status, payload address and free statistics over all arenas.
// cfg_*: register writes, always ready; write only while the block is idle.
// Each arena's free table is a row of FREE_ENTRIES cells. Fit search, insert
// position and statistics ripple down the row one cell per clock, so every
// table walk visits every cell; table updates shift the whole row in the
// update state.
// An allocate runs a search walk, an update if it succeeds, and a statistics
// walk; a zero request or null free runs the statistics walk only. A free
// scans the live block memory, one entry per cycle, up to a match, then an
// insert position walk, an update if it fits, and a statistics walk.
// One request is in flight at a time; s_tready is high only in idle. A
// finished result waits in the output register while m_tready is low; the
// next request may be taken meanwhile, and its result holds in the reply
// state until the output register has been emptied.
// Reset: each arena holds one free block covering it less one header, the
// live table is empty, registers take their defaults. No clearing pass.
module segregated_free_list_allocator_top
    import slfa_pkg::*;
#(
    parameter int SMALL_ARENA_BYTES  = 4096,
    parameter int MEDIUM_ARENA_BYTES = 16384,
    parameter int LARGE_ARENA_BYTES  = 65536,
    parameter int HEADER_BYTES       = 16,
    parameter int FREE_ENTRIES       = 64,
    parameter int LIVE_ENTRIES       = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // request_size[15:0], address[32:16], zero fill
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // status[1:0], payload_address[18:2],
                                   // free_block_count[26:19], free_bytes_total[43:27],
                                   // largest_free_block[59:44], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int              SLOT_W     = $clog2(LIVE_ENTRIES);
    localparam int              WAIT_W     = $clog2(FREE_ENTRIES + 2);
    localparam logic [WAIT_W-1:0] WAIT_LAST = WAIT_W'(FREE_ENTRIES + 1);
    localparam logic [SLOT_W:0] LIVE_N     = (SLOT_W+1)'(LIVE_ENTRIES);
    localparam logic [IDX_W-1:0] FREE_N    = IDX_W'(FREE_ENTRIES);
    localparam logic [ADDR_W:0] HW         = (ADDR_W+1)'(HEADER_BYTES);
    localparam logic [ADDR_W:0] MED_BASE   = (ADDR_W+1)'(SMALL_ARENA_BYTES);
    localparam logic [ADDR_W:0] LARGE_BASE = (ADDR_W+1)'(SMALL_ARENA_BYTES
                                                         + MEDIUM_ARENA_BYTES);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SEARCH = 8'b0000_0010,
        S_LOOKUP = 8'b0000_0100,
        S_PLACE  = 8'b0000_1000,
        S_UPDATE = 8'b0001_0000,
        S_STATS  = 8'b0010_0000,
        S_REPLY  = 8'b0100_0000,
        S_SPARE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic              fit_mode_reg, merge_en_reg;
    logic [15:0]       small_limit_reg, medium_limit_reg;

    // request
    logic              kind_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [1:0]        arena_reg;
    logic [WAIT_W-1:0] wait_reg;
    logic [1:0]        status_reg;
    logic [ADDR_W-1:0] pay_reg;
    op_t               op_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [SIZE_W-1:0] lsize_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              use_fresh_reg;

    // live block memory and slot allocation
    logic [ADDR_W-1:0] lmem_addr [LIVE_ENTRIES];
    logic [SIZE_W-1:0] lmem_size [LIVE_ENTRIES];
    logic [SLOT_W-1:0] stack_mem [LIVE_ENTRIES];
    logic [LIVE_ENTRIES-1:0] lvalid_reg;
    logic [SLOT_W:0]   fresh_reg, sp_reg, scan_reg;
    logic [SLOT_W-1:0] sp_m1, stk_q_reg;
    logic              rd_ok_reg, lrd_vld_reg;
    logic [SLOT_W-1:0] lrd_idx_reg;
    logic [ADDR_W-1:0] lrd_addr_reg;
    logic [SIZE_W-1:0] lrd_size_reg;
    logic              live_full;

    logic [IDX_W-1:0]  cnt_reg [3];

    // output register
    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg;

    cmd_t cmd_base, cmd_s, cmd_m, cmd_l;
    acc_t acc_s, acc_m, acc_l, acc_sel;

    logic [ADDR_W:0]   start_w, split_min, pay_w;
    logic [1:0]        arena_of_addr;
    logic [9:0]        cnt_sum;
    logic [ADDR_W+1:0] bytes_sum;
    logic [SIZE_W-1:0] big_ms, big_all;
    logic              mp_w, mn_w;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign live_full = (fresh_reg == LIVE_N) && (sp_reg == '0);
    assign sp_m1     = SLOT_W'(sp_reg - (SLOT_W+1)'(1));

    always_comb
    begin
        start_w   = {1'b0, addr_reg} - HW;
        split_min = (ADDR_W+1)'(req_reg) + HW + HW + (ADDR_W+1)'(1);
        pay_w     = {1'b0, acc_sel.fit_addr} + HW;
        if ({1'b0, addr_reg} < MED_BASE)
            arena_of_addr = ARENA_SMALL;
        else if ({1'b0, addr_reg} < LARGE_BASE)
            arena_of_addr = ARENA_MEDIUM;
        else
            arena_of_addr = ARENA_LARGE;
        case (arena_reg)
            ARENA_SMALL:  acc_sel = acc_s;
            ARENA_MEDIUM: acc_sel = acc_m;
            default:      acc_sel = acc_l;
        endcase
        mp_w = merge_en_reg && acc_sel.mp;
        mn_w = merge_en_reg && acc_sel.mn;
    end

    // broadcast the command; only the chosen arena sees a table operation
    always_comb
    begin
        cmd_base.op        = OP_NOP;
        cmd_base.pos       = pos_reg;
        cmd_base.req       = req_reg;
        cmd_base.start     = start_w[ADDR_W-1:0];
        cmd_base.size      = lsize_reg;
        cmd_base.fit_first = fit_mode_reg;
        cmd_s = cmd_base;
        cmd_m = cmd_base;
        cmd_l = cmd_base;
        if (state_reg == S_UPDATE)
        begin
            case (arena_reg)
                ARENA_SMALL:  cmd_s.op = op_reg;
                ARENA_MEDIUM: cmd_m.op = op_reg;
                default:      cmd_l.op = op_reg;
            endcase
        end
    end

    slfa_chain #(
        .N (FREE_ENTRIES), .HDR (HEADER_BYTES),
        .BASE (0), .BYTES (SMALL_ARENA_BYTES)
    ) u_small (
        .clk (clk), .rst_n (rst_n), .cmd (cmd_s), .total (acc_s)
    );

    slfa_chain #(
        .N (FREE_ENTRIES), .HDR (HEADER_BYTES),
        .BASE (SMALL_ARENA_BYTES), .BYTES (MEDIUM_ARENA_BYTES)
    ) u_medium (
        .clk (clk), .rst_n (rst_n), .cmd (cmd_m), .total (acc_m)
    );

    slfa_chain #(
        .N (FREE_ENTRIES), .HDR (HEADER_BYTES),
        .BASE (SMALL_ARENA_BYTES + MEDIUM_ARENA_BYTES), .BYTES (LARGE_ARENA_BYTES)
    ) u_large (
        .clk (clk), .rst_n (rst_n), .cmd (cmd_l), .total (acc_l)
    );

    // statistics across arenas
    always_comb
    begin
        cnt_sum   = 10'(acc_s.cnt) + 10'(acc_m.cnt) + 10'(acc_l.cnt);
        bytes_sum = (ADDR_W+2)'(acc_s.bytes) + (ADDR_W+2)'(acc_m.bytes)
                  + (ADDR_W+2)'(acc_l.bytes);
        big_ms    = (acc_s.big > acc_m.big) ? acc_s.big : acc_m.big;
        big_all   = (big_ms > acc_l.big) ? big_ms : acc_l.big;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!s_tuser)
                        state_next = (s_tdata[15:0] == '0) ? S_STATS : S_SEARCH;
                    else
                        state_next = (s_tdata[32:16] == '0) ? S_STATS : S_LOOKUP;
                end
            end
            S_SEARCH:
            begin
                if (wait_reg == WAIT_LAST)
                    state_next = (!acc_sel.fit_found || live_full) ? S_STATS : S_UPDATE;
            end
            S_LOOKUP:
            begin
                if (rd_ok_reg && lrd_vld_reg && lrd_addr_reg == addr_reg)
                    state_next = S_PLACE;
                else if (scan_reg == LIVE_N && !rd_ok_reg)
                    state_next = S_STATS;
            end
            S_PLACE:
            begin
                if (wait_reg == WAIT_LAST)
                begin
                    if (!mp_w && !mn_w && cnt_reg[arena_reg] >= FREE_N)
                        state_next = S_STATS;
                    else
                        state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_STATS;
            end
            S_STATS:
            begin
                if (wait_reg == WAIT_LAST)
                    state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fit_mode_reg     <= 1'b0;
            merge_en_reg     <= 1'b1;
            small_limit_reg  <= 16'd64;
            medium_limit_reg <= 16'd1024;
            wait_reg         <= '0;
            scan_reg         <= '0;
            rd_ok_reg        <= 1'b0;
            lrd_vld_reg      <= 1'b0;
            lvalid_reg       <= '0;
            fresh_reg        <= '0;
            sp_reg           <= '0;
            cnt_reg[0]       <= IDX_W'(1);
            cnt_reg[1]       <= IDX_W'(1);
            cnt_reg[2]       <= IDX_W'(1);
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_FIT_MODE:     fit_mode_reg     <= cfg_data[0];
                    CFG_MERGE_ENABLE: merge_en_reg     <= cfg_data[0];
                    CFG_SMALL_LIMIT:  small_limit_reg  <= cfg_data;
                    CFG_MEDIUM_LIMIT: medium_limit_reg <= cfg_data;
                    default:          fit_mode_reg     <= fit_mode_reg;
                endcase
            end

            // live table read pipeline for the free lookup
            rd_ok_reg   <= (state_reg == S_LOOKUP) && (scan_reg < LIVE_N);
            lrd_vld_reg <= lvalid_reg[scan_reg[SLOT_W-1:0]];

            case (state_reg)
                S_IDLE:
                begin
                    wait_reg <= '0;
                    scan_reg <= '0;
                end
                S_SEARCH, S_PLACE, S_STATS:
                begin
                    wait_reg <= (wait_reg == WAIT_LAST) ? '0 : wait_reg + WAIT_W'(1);
                end
                S_LOOKUP:
                begin
                    wait_reg <= '0;
                    if (scan_reg < LIVE_N)
                        scan_reg <= scan_reg + (SLOT_W+1)'(1);
                end
                S_UPDATE:
                begin
                    wait_reg <= '0;
                    case (op_reg)
                        OP_DELETE, OP_MERGE_BOTH:
                            cnt_reg[arena_reg] <= cnt_reg[arena_reg] - IDX_W'(1);
                        OP_INSERT:
                            cnt_reg[arena_reg] <= cnt_reg[arena_reg] + IDX_W'(1);
                        default:
                            cnt_reg[arena_reg] <= cnt_reg[arena_reg];
                    endcase
                    if (!kind_reg)
                    begin
                        lvalid_reg[slot_reg] <= 1'b1;
                        if (use_fresh_reg)
                            fresh_reg <= fresh_reg + (SLOT_W+1)'(1);
                        else
                            sp_reg <= sp_reg - (SLOT_W+1)'(1);
                    end
                    else
                    begin
                        lvalid_reg[slot_reg] <= 1'b0;
                        sp_reg <= sp_reg + (SLOT_W+1)'(1);
                    end
                end
                S_REPLY:
                begin
                    wait_reg <= '0;
                end
                default:
                begin
                    wait_reg <= '0;
                end
            endcase

            // output register: hold until taken, reload from the reply state
            if (state_reg == S_REPLY && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_reg   <= s_tuser;
                    req_reg    <= s_tdata[15:0];
                    addr_reg   <= s_tdata[32:16];
                    pay_reg    <= '0;
                    status_reg <= (!s_tuser && s_tdata[15:0] == '0) ? STS_NOFIT : STS_OK;
                    if (s_tdata[15:0] <= small_limit_reg)
                        arena_reg <= ARENA_SMALL;
                    else if (s_tdata[15:0] <= medium_limit_reg)
                        arena_reg <= ARENA_MEDIUM;
                    else
                        arena_reg <= ARENA_LARGE;
                end
            end
            S_SEARCH:
            begin
                if (wait_reg == WAIT_LAST)
                begin
                    if (!acc_sel.fit_found)
                        status_reg <= STS_NOFIT;
                    else if (live_full)
                        status_reg <= STS_FULL;
                    else
                    begin
                        pos_reg       <= acc_sel.fit_idx;
                        pay_reg       <= pay_w[ADDR_W-1:0];
                        use_fresh_reg <= (fresh_reg < LIVE_N);
                        slot_reg      <= (fresh_reg < LIVE_N) ? fresh_reg[SLOT_W-1:0]
                                                              : stk_q_reg;
                        if ((ADDR_W+1)'(acc_sel.fit_size) >= split_min)
                        begin
                            op_reg    <= OP_SPLIT;
                            lsize_reg <= req_reg;
                        end
                        else
                        begin
                            op_reg    <= OP_DELETE;
                            lsize_reg <= acc_sel.fit_size;
                        end
                    end
                end
            end
            S_LOOKUP:
            begin
                if (rd_ok_reg && lrd_vld_reg && lrd_addr_reg == addr_reg)
                begin
                    slot_reg  <= lrd_idx_reg;
                    lsize_reg <= lrd_size_reg;
                    arena_reg <= arena_of_addr;
                end
                else if (scan_reg == LIVE_N && !rd_ok_reg)
                    status_reg <= STS_UNKNOWN;
            end
            S_PLACE:
            begin
                if (wait_reg == WAIT_LAST)
                begin
                    pos_reg <= acc_sel.pos_idx;
                    if (mp_w && mn_w)
                        op_reg <= OP_MERGE_BOTH;
                    else if (mp_w)
                        op_reg <= OP_MERGE_PREV;
                    else if (mn_w)
                        op_reg <= OP_MERGE_NEXT;
                    else if (cnt_reg[arena_reg] >= FREE_N)
                        status_reg <= STS_FULL;
                    else
                        op_reg <= OP_INSERT;
                end
            end
            S_REPLY:
            begin
                if (!m_tvalid_reg || m_tready)
                    m_tdata_reg <= {4'd0, big_all, bytes_sum[ADDR_W-1:0], cnt_sum[7:0],
                                    pay_reg, status_reg};
            end
            default:
            begin
                kind_reg <= kind_reg;
            end
        endcase
    end

    // live block memory, recycled slot stack
    always_ff @(posedge clk)
    begin
        lrd_addr_reg <= lmem_addr[scan_reg[SLOT_W-1:0]];
        lrd_size_reg <= lmem_size[scan_reg[SLOT_W-1:0]];
        lrd_idx_reg  <= scan_reg[SLOT_W-1:0];
        stk_q_reg    <= stack_mem[sp_m1];
        if (state_reg == S_UPDATE)
        begin
            if (!kind_reg)
            begin
                lmem_addr[slot_reg] <= pay_reg;
                lmem_size[slot_reg] <= lsize_reg;
            end
            else
                stack_mem[sp_reg[SLOT_W-1:0]] <= slot_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= FREE_N && cnt_reg[1] <= FREE_N && cnt_reg[2] <= FREE_N)
        else $error("free table count beyond capacity");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= fresh_reg)
        else $error("recycled slot stack deeper than slots handed out");

    a_alloc_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && !kind_reg) |-> !live_full)
        else $error("allocate committed with live table full");

    a_reply_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_REPLY))
        else $error("result raised outside reply state");
`endif

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    import slfa_pkg::*;

    localparam int SMALL_BYTES  = 4096;
    localparam int MEDIUM_BYTES = 16384;
    localparam int LARGE_BYTES  = 65536;
    localparam int HDR          = 16;
    localparam int FREE_N       = 64;
    localparam int LIVE_N       = 128;
    localparam int IDLE_LIMIT   = 20000;
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] req;
        logic [16:0] addr;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] payload;
        logic [7:0]  blocks;
        logic [16:0] bytes;
        logic [15:0] largest;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    segregated_free_list_allocator_top dut (.*);

    // Clock: 10 time units per period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow heap state used to predict every answer.
    int unsigned fb_addr [3][FREE_N];
    int unsigned fb_size [3][FREE_N];
    int unsigned fb_cnt  [3];
    bit          lv_valid[LIVE_N];
    int unsigned lv_addr [LIVE_N];
    int unsigned lv_size [LIVE_N];
    bit          m_fit_first;
    bit          m_merge;
    int unsigned m_small_lim;
    int unsigned m_medium_lim;

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    int unsigned live_payloads[$];  // addresses believed live, for free stimulus
    int       errors;
    int       sent;
    int       received;
    int       idle_cycles;
    bit       s_taken;

    function automatic int unsigned arena_base(int a);
        return (a == 0) ? 0 : ((a == 1) ? SMALL_BYTES : SMALL_BYTES + MEDIUM_BYTES);
    endfunction

    function automatic void heap_reset();
        int a;
        for (a = 0; a < 3; a++)
        begin
            fb_addr[a][0] = arena_base(a);
            fb_size[a][0] = ((a == 0) ? SMALL_BYTES : (a == 1) ? MEDIUM_BYTES : LARGE_BYTES)
                            - HDR;
            fb_cnt[a] = 1;
        end
        for (int i = 0; i < LIVE_N; i++)
            lv_valid[i] = 1'b0;
        m_fit_first  = 1'b0;
        m_merge      = 1'b1;
        m_small_lim  = 64;
        m_medium_lim = 1024;
    endfunction

    function automatic logic [1:0] heap_alloc(int unsigned n, output int unsigned pay);
        int a, best, slot;
        int unsigned c, base, sz;
        best = -1;
        slot = -1;
        pay = 0;
        if (n == 0)
            return STS_NOFIT;
        a = (n <= m_small_lim) ? 0 : ((n <= m_medium_lim) ? 1 : 2);
        c = fb_cnt[a];
        for (int i = 0; i < c; i++)
        begin
            if (fb_size[a][i] >= n)
            begin
                if (m_fit_first)
                begin
                    best = i;
                    break;
                end
                if (best < 0 || fb_size[a][i] < fb_size[a][best])
                    best = i;
            end
        end
        if (best < 0)
            return STS_NOFIT;
        for (int i = 0; i < LIVE_N; i++)
            if (!lv_valid[i])
            begin
                slot = i;
                break;
            end
        if (slot < 0)
            return STS_FULL;
        base = fb_addr[a][best];
        sz   = fb_size[a][best];
        if (sz >= n + 2 * HDR + 1)
        begin
            fb_addr[a][best] = base + HDR + n;
            fb_size[a][best] = sz - n - HDR;
            lv_size[slot] = n;
        end
        else
        begin
            for (int i = best; i < c - 1; i++)
            begin
                fb_addr[a][i] = fb_addr[a][i+1];
                fb_size[a][i] = fb_size[a][i+1];
            end
            fb_cnt[a] = c - 1;
            lv_size[slot] = sz;
        end
        lv_valid[slot] = 1'b1;
        lv_addr[slot]  = base + HDR;
        pay = base + HDR;
        return STS_OK;
    endfunction

    function automatic logic [1:0] heap_free(int unsigned addr);
        int a, slot;
        int unsigned c, pos, start, size;
        bit mn, mp;
        slot = -1;
        if (addr == 0)
            return STS_OK;
        for (int i = 0; i < LIVE_N; i++)
            if (lv_valid[i] && lv_addr[i] == addr)
            begin
                slot = i;
                break;
            end
        if (slot < 0)
            return STS_UNKNOWN;
        a = (addr < arena_base(1)) ? 0 : ((addr < arena_base(2)) ? 1 : 2);
        c = fb_cnt[a];
        start = addr - HDR;
        size = lv_size[slot];
        pos = 0;
        while (pos < c && fb_addr[a][pos] < start)
            pos++;
        mn = m_merge && pos < c && start + HDR + size == fb_addr[a][pos];
        mp = m_merge && pos > 0 && fb_addr[a][pos-1] + HDR + fb_size[a][pos-1] == start;
        if (mp && mn)
        begin
            fb_size[a][pos-1] += 2 * HDR + size + fb_size[a][pos];
            for (int i = pos; i < c - 1; i++)
            begin
                fb_addr[a][i] = fb_addr[a][i+1];
                fb_size[a][i] = fb_size[a][i+1];
            end
            fb_cnt[a] = c - 1;
        end
        else if (mp)
            fb_size[a][pos-1] += HDR + size;
        else if (mn)
        begin
            fb_size[a][pos] += size + HDR;
            fb_addr[a][pos] = start;
        end
        else
        begin
            if (c >= FREE_N)
                return STS_FULL;
            for (int i = c; i > pos; i--)
            begin
                fb_addr[a][i] = fb_addr[a][i-1];
                fb_size[a][i] = fb_size[a][i-1];
            end
            fb_addr[a][pos] = start;
            fb_size[a][pos] = size;
            fb_cnt[a] = c + 1;
        end
        lv_valid[slot] = 1'b0;
        return STS_OK;
    endfunction

    // Compute the answer for one request and advance the shadow heap.
    function automatic answer_t heap_step(request_t r);
        answer_t     ans;
        int unsigned pay, cnt, bytes, big;
        pay = 0;
        cnt = 0;
        bytes = 0;
        big = 0;
        if (r.kind == KIND_ALLOC)
            ans.status = heap_alloc(r.req, pay);
        else
            ans.status = heap_free(r.addr);
        for (int a = 0; a < 3; a++)
            for (int i = 0; i < fb_cnt[a]; i++)
            begin
                cnt++;
                bytes += fb_size[a][i];
                if (fb_size[a][i] > big)
                    big = fb_size[a][i];
            end
        ans.payload = pay[16:0];
        ans.blocks  = cnt[7:0];
        ans.bytes   = bytes[16:0];
        ans.largest = big[15:0];
        return ans;
    endfunction

    // Driver: hold each request until its transfer, insert random gaps.
    int gap_left;

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 0;
        if (p < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_taken)
        begin
            // previous transfer done or nothing offered: pick the next move
            if (s_tvalid)
                void'(pending_reqs.pop_front());
            if (gap_left > 0 || (s_tvalid && pick_gap() > 0 && $urandom_range(0, 1)))
            begin
                s_tvalid <= 1'b0;
                gap_left <= (gap_left > 0) ? gap_left - 1 : pick_gap();
            end
            else if (pending_reqs.size() > 0)
            begin
                request_t r;
                r = pending_reqs[0];
                s_tvalid <= 1'b1;
                s_tuser  <= r.kind;
                s_tdata  <= {7'd0, r.addr, r.req};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Predict at the accepting edge so expectations track acceptance order.
    always @(posedge clk)
    begin
        s_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            request_t r;
            answer_t  e;
            r.kind = s_tuser;
            r.req  = s_tdata[15:0];
            r.addr = s_tdata[32:16];
            e = heap_step(r);
            expected_answers.push_back(e);
            if (r.kind == KIND_ALLOC && e.status == STS_OK)
                live_payloads.push_back(e.payload);
            sent++;
        end
    end

    // Receiver stalls.
    int stall_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            m_tready <= 1'b1;
    end

    // Monitor: compare each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            answer_t got, e;
            got.status  = m_tdata[1:0];
            got.payload = m_tdata[18:2];
            got.blocks  = m_tdata[26:19];
            got.bytes   = m_tdata[43:27];
            got.largest = m_tdata[59:44];
            received++;
            if (expected_answers.size() == 0)
            begin
                $error("result with no request pending: %h", m_tdata);
                errors++;
            end
            else
            begin
                e = expected_answers.pop_front();
                if (got.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, got.status);
                    errors++;
                end
                if (got.payload !== e.payload)
                begin
                    $error("payload_address exp %0d got %0d", e.payload, got.payload);
                    errors++;
                end
                if (got.blocks !== e.blocks)
                begin
                    $error("free_block_count exp %0d got %0d", e.blocks, got.blocks);
                    errors++;
                end
                if (got.bytes !== e.bytes)
                begin
                    $error("free_bytes_total exp %0d got %0d", e.bytes, got.bytes);
                    errors++;
                end
                if (got.largest !== e.largest)
                begin
                    $error("largest_free_block exp %0d got %0d", e.largest, got.largest);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_req(logic kind, int unsigned sz, int unsigned addr);
        request_t r;
        r.kind = kind;
        r.req  = sz[15:0];
        r.addr = addr[16:0];
        pending_reqs.push_back(r);
    endtask

    // Pick a free target: mostly a live payload, sometimes garbage.
    task automatic queue_free_any();
        int p, k;
        p = $urandom_range(0, 99);
        if (p < 80 && live_payloads.size() > 0)
        begin
            k = $urandom_range(0, live_payloads.size() - 1);
            queue_req(KIND_FREE, 0, live_payloads[k]);
            if ($urandom_range(0, 9) != 0)
                live_payloads.delete(k);  // occasionally keep it for a double free
        end
        else if (p < 88)
            queue_req(KIND_FREE, 0, 0);
        else
            queue_req(KIND_FREE, $urandom_range(0, 65535), $urandom_range(0, 131071));
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_answers.size() == 0);
        repeat (2 * FREE_N + LIVE_N + 20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_FIT_MODE:     m_fit_first  = val[0];
            CFG_MERGE_ENABLE: m_merge      = val[0];
            CFG_SMALL_LIMIT:  m_small_lim  = val;
            default:          m_medium_lim = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random phase: keep the pending queue short so frees target blocks already predicted live.
    task automatic random_phase(int count);
        int p;
        for (int i = 0; i < count; i++)
        begin
            wait (pending_reqs.size() < 4);
            p = $urandom_range(0, 99);
            if (p < 55)
            begin
                if ($urandom_range(0, 3) == 0)
                    queue_req(KIND_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 131071));
                else if ($urandom_range(0, 1))
                    queue_req(KIND_ALLOC, $urandom_range(1, 80), $urandom_range(0, 131071));
                else
                    queue_req(KIND_ALLOC, $urandom_range(1, 1500), $urandom_range(0, 131071));
            end
            else
                queue_free_any();
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        sent = 0;
        received = 0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FIT_MODE;
        cfg_data = '0;
        heap_reset();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero request, extremes, null and unknown frees, double free.
        queue_req(KIND_ALLOC, 0, 131071);
        queue_req(KIND_ALLOC, 65535, 0);
        queue_req(KIND_ALLOC, 1, 0);
        queue_req(KIND_ALLOC, 64, 0);
        queue_req(KIND_ALLOC, 65, 0);
        queue_req(KIND_ALLOC, 1024, 0);
        queue_req(KIND_ALLOC, 1025, 0);
        queue_req(KIND_ALLOC, 65520, 0);
        queue_req(KIND_FREE, 65535, 0);
        queue_req(KIND_FREE, 0, 131071);
        queue_req(KIND_FREE, 0, 16);
        queue_req(KIND_FREE, 0, 16);          // double free of the first block
        queue_req(KIND_FREE, 0, 16 + 17);     // second small block
        queue_req(KIND_ALLOC, 4070, 0);       // above the medium limit: large arena, split
        drain();
        live_payloads.delete();
        for (int i = 0; i < LIVE_N; i++)
            if (lv_valid[i])
                live_payloads.push_back(lv_addr[i]);

        random_phase(100);

        // First fit, no merging: pack the small arena to fill its free table.
        write_reg(CFG_FIT_MODE, 16'd1);
        write_reg(CFG_MERGE_ENABLE, 16'd0);
        write_reg(CFG_SMALL_LIMIT, 16'd16);
        for (int i = 0; i < 140; i++)
            queue_req(KIND_ALLOC, $urandom_range(1, 16), 0);   // runs into the live limit
        drain();
        live_payloads.delete();
        for (int i = 0; i < LIVE_N; i++)
            if (lv_valid[i])
                live_payloads.push_back(lv_addr[i]);
        // Free every other live block to run the free table into its capacity.
        live_payloads.sort();
        for (int i = 0; i < live_payloads.size(); i += 2)
            queue_req(KIND_FREE, 0, live_payloads[i]);
        drain();
        live_payloads.delete();
        for (int i = 0; i < LIVE_N; i++)
            if (lv_valid[i])
                live_payloads.push_back(lv_addr[i]);

        random_phase(80);

        // Limits out of order and at extremes.
        write_reg(CFG_MERGE_ENABLE, 16'd1);
        write_reg(CFG_SMALL_LIMIT, 16'd65535);
        write_reg(CFG_MEDIUM_LIMIT, 16'd1);
        random_phase(60);

        write_reg(CFG_FIT_MODE, 16'd0);
        write_reg(CFG_SMALL_LIMIT, 16'd1);
        write_reg(CFG_MEDIUM_LIMIT, 16'd65535);
        // release everything believed live so merges rebuild big blocks
        live_payloads.delete();
        for (int i = 0; i < LIVE_N; i++)
            if (lv_valid[i])
                live_payloads.push_back(lv_addr[i]);
        while (live_payloads.size() > 0)
            queue_req(KIND_FREE, 0, live_payloads.pop_front());
        drain();
        random_phase(60);

        write_reg(CFG_SMALL_LIMIT, 16'd64);
        write_reg(CFG_MEDIUM_LIMIT, 16'd1024);
        random_phase(60);

        $display("Covered %0d requests and %0d results across fit modes, merge on/off,",
                 sent, received);
        $display("limit extremes, full tables, unknown and double frees.");
        if (errors == 0 && expected_answers.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
design/slfa_pkg.sv
design/slfa_cell.sv
design/slfa_chain.sv
design/segregated_free_list_allocator_top.sv
tb/sv/tb_top.sv
